/* src/uer_pkg.sv */
`default_nettype none

package uer_pkg;

    localparam int unsigned TIMEOUT_W   = 10;
    localparam int unsigned TICK_W      = 20;
    localparam int unsigned DIST_W      = 18;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 10'd50;
    localparam logic [TICK_W-1:0]    TICKS_PER_MS    = 20'd1000;
    localparam logic [TICK_W-1:0]    PRE_LOW_TICKS   = 20'd2;
    localparam logic [TICK_W-1:0]    TRIG_HIGH_TICKS = 20'd12;

    // distance = (w*343 + 999) / 2000, done as ((w*343 + 999) >> 4) / 125
    localparam int unsigned SCALED_W = 29;
    localparam int unsigned QUART_W  = SCALED_W - 4;
    localparam logic [8:0]          SOUND_MUL  = 9'd343;
    localparam logic [9:0]          ROUND_ADD  = 10'd999;
    // ceil(2^32 / 125); exact for every 25-bit dividend
    localparam int unsigned         RECIP_SH   = 32;
    localparam logic [25:0]         RECIP_125  = 26'd34359739;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_PRE_LOW   = 3'd2,
        PH_TRIG_HIGH = 3'd3,
        PH_WAIT_RISE = 3'd4,
        PH_MEASURE   = 3'd5
    } t_phase;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic              timed_out;
        logic [TICK_W-1:0] pulse;
    } t_res;

endpackage

`default_nettype wire

/* src/ultrasonic_echo_ranger.sv */
`default_nettype none

// Ranging controller for a trigger/echo ultrasonic sensor. Feed one input beat
// per microsecond tick (start request plus sampled echo level); every input
// beat yields exactly one result beat with the trigger level for that tick,
// busy/done/timeout flags, the last echo width in ticks and the distance in mm.
// A start while idle waits for echo low, drives trigger low for two ticks and
// high for twelve (PRE_LOW_TICKS and TRIG_HIGH_TICKS), waits for the echo rise
// and times the high pulse; each wait and the measurement abort once their tick
// count passes the timeout register times 1000. Throughput is one beat per
// clock cycle while o_stall is low. The sequencer itself updates in the cycle
// a beat is taken; the result then runs through a three-stage pipeline
// (flags and width, speed-of-sound product, reciprocal multiply for the
// divide by 2000); o_valid rises once the result has passed r_s1, r_s2 and
// r_s3 in that order. Empty stages collapse, so input beats are still taken
// while a finished result waits on o_valid; o_stall rises only when all
// three stages hold beats and the output is stalled. The timeout
// register may be written at any time the block is idle and takes effect on
// the next tick.
module ultrasonic_echo_ranger #(
    parameter logic [uer_pkg::TICK_W-1:0] PRE_LOW_TICKS   = uer_pkg::PRE_LOW_TICKS,
    parameter logic [uer_pkg::TICK_W-1:0] TRIG_HIGH_TICKS = uer_pkg::TRIG_HIGH_TICKS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [uer_pkg::TIMEOUT_W-1:0] i_cfg_wr_data,
    // input beats
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_start_req,
    input  wire logic                          i_echo,
    // result beats
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_trigger,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_timed_out,
    output logic [uer_pkg::TICK_W-1:0]         o_echo_width,
    output logic [uer_pkg::DIST_W-1:0]         o_dist_mm
);

    localparam int unsigned TW = uer_pkg::TICK_W;

    // per-phase limit in ticks, held pre-multiplied
    logic [TW-1:0] r_limit;

    // sequencer state
    uer_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]   r_elapsed, n_elapsed;
    logic [TW-1:0]   r_last_pulse, n_last_pulse;

    // pipeline
    logic                             r_v1, r_v2, r_v3;
    uer_pkg::t_res                    r_s1, r_s2, r_s3;
    uer_pkg::t_res                    n_res;
    logic [uer_pkg::QUART_W-1:0]      r_quart;
    logic [uer_pkg::DIST_W-1:0]       r_dist;
    logic [uer_pkg::SCALED_W-1:0]     scaled;
    logic [uer_pkg::QUART_W+25:0]     recip_prod;

    logic rdy1, rdy2, rdy3, in_take;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign in_take = i_valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TW'(uer_pkg::TIMEOUT_RST) * uer_pkg::TICKS_PER_MS;
        end else if (i_cfg_wr_en) begin
            r_limit <= TW'(i_cfg_wr_data) * uer_pkg::TICKS_PER_MS;
        end
    end

    // ---- sequencer: one tick per accepted beat ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uer_pkg::PH_IDLE;
            r_elapsed    <= '0;
            r_last_pulse <= '0;
        end else if (in_take) begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_last_pulse <= n_last_pulse;
        end
    end

    always_comb begin
        uer_pkg::t_phase ph;
        logic [TW-1:0]   el;
        logic [TW-1:0]   el_inc;
        logic            trig;
        logic            done;
        logic            tmo;

        // idle (or a code that means nothing) picks up a start on this tick
        ph = r_phase;
        el = r_elapsed;
        unique case (r_phase)
            uer_pkg::PH_WAIT_LOW, uer_pkg::PH_PRE_LOW, uer_pkg::PH_TRIG_HIGH,
            uer_pkg::PH_WAIT_RISE, uer_pkg::PH_MEASURE: begin
            end
            default: begin
                ph = uer_pkg::PH_IDLE;
                if (i_start_req) begin
                    ph = uer_pkg::PH_WAIT_LOW;
                    el = '0;
                end
            end
        endcase

        el_inc       = el + TW'(1);
        n_phase      = ph;
        n_elapsed    = el;
        n_last_pulse = r_last_pulse;
        trig         = 1'b0;
        done         = 1'b0;
        tmo          = 1'b0;

        unique case (ph)
            uer_pkg::PH_WAIT_LOW: begin
                if (!i_echo) begin
                    n_phase   = uer_pkg::PH_PRE_LOW;
                    n_elapsed = '0;
                end else begin
                    n_elapsed = el_inc;
                    tmo       = el_inc > r_limit;
                end
            end
            uer_pkg::PH_PRE_LOW: begin
                n_elapsed = el_inc;
                if (el_inc >= PRE_LOW_TICKS) begin
                    n_phase   = uer_pkg::PH_TRIG_HIGH;
                    n_elapsed = '0;
                end
            end
            uer_pkg::PH_TRIG_HIGH: begin
                trig      = 1'b1;
                n_elapsed = el_inc;
                if (el_inc >= TRIG_HIGH_TICKS) begin
                    n_phase   = uer_pkg::PH_WAIT_RISE;
                    n_elapsed = '0;
                end
            end
            uer_pkg::PH_WAIT_RISE: begin
                if (i_echo) begin
                    // rising tick is the first high tick
                    n_phase   = uer_pkg::PH_MEASURE;
                    n_elapsed = TW'(1);
                    tmo       = r_limit == '0;
                end else begin
                    n_elapsed = el_inc;
                    tmo       = el_inc > r_limit;
                end
            end
            uer_pkg::PH_MEASURE: begin
                if (!i_echo) begin
                    done         = 1'b1;
                    n_last_pulse = el;
                    n_phase      = uer_pkg::PH_IDLE;
                    n_elapsed    = '0;
                end else begin
                    n_elapsed = el_inc;
                    tmo       = el_inc > r_limit;
                end
            end
            default: begin
            end
        endcase

        if (tmo) begin
            done         = 1'b1;
            n_last_pulse = '0;
            n_phase      = uer_pkg::PH_IDLE;
            n_elapsed    = '0;
        end

        n_res.trigger   = trig;
        n_res.busy      = n_phase != uer_pkg::PH_IDLE;
        n_res.done      = done;
        n_res.timed_out = tmo;
        n_res.pulse     = n_last_pulse;
    end

    // ---- result pipeline ----
    assign scaled = uer_pkg::SCALED_W'(r_s1.pulse) * uer_pkg::SCALED_W'(uer_pkg::SOUND_MUL)
                  + uer_pkg::SCALED_W'(uer_pkg::ROUND_ADD);

    assign recip_prod = (uer_pkg::QUART_W + 26)'(r_quart)
                      * (uer_pkg::QUART_W + 26)'(uer_pkg::RECIP_125);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= n_res;
        end
        if (rdy2 && r_v1) begin
            r_s2    <= r_s1;
            r_quart <= scaled[uer_pkg::SCALED_W-1:4];
        end
        if (rdy3 && r_v2) begin
            r_s3   <= r_s2;
            r_dist <= recip_prod[uer_pkg::RECIP_SH +: uer_pkg::DIST_W];
        end
    end

    assign o_valid      = r_v3;
    assign o_trigger    = r_s3.trigger;
    assign o_busy_res   = r_s3.busy;
    assign o_done_res   = r_s3.done;
    assign o_timed_out  = r_s3.timed_out;
    assign o_echo_width = r_s3.pulse;
    assign o_dist_mm    = r_dist;

endmodule

`default_nettype wire

/* src/uer_checker.sv */
`default_nettype none

module uer_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_trigger,
    input wire logic        o_busy_res,
    input wire logic        o_done_res,
    input wire logic        o_timed_out,
    input wire logic [19:0] o_echo_width,
    input wire logic [17:0] o_dist_mm
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_echo_width) && $stable(o_dist_mm))
        else $error("stalled result changed");

    a_tmo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timed_out |-> o_done_res && o_echo_width == '0 && o_dist_mm == '0)
        else $error("timeout without done or with nonzero width");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_trigger |-> o_busy_res && !o_done_res)
        else $error("trigger high outside a cycle");

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_echo_width == '0 |-> o_dist_mm == '0)
        else $error("distance without a width");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_trigger   (o_trigger),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_timed_out (o_timed_out),
    .o_echo_width(o_echo_width),
    .o_dist_mm   (o_dist_mm)
);

`default_nettype wire

/* tb/ultrasonic_echo_ranger_tb.sv */
`default_nettype none

module ultrasonic_echo_ranger_tb;

    // Own copies of the sequencer constants, kept apart from the package
    localparam logic [9:0]  WAKE_TIMEOUT_MS = 10'd50;
    localparam logic [19:0] LOW_LEAD_TICKS  = 20'd2;
    localparam logic [19:0] PULSE_TICKS     = 20'd12;
    localparam int unsigned TRIG_SPAN       = 14;   // low lead plus trigger pulse
    localparam int unsigned PHASE_TICKS     = 30;   // minimum ranging beats per timeout setting
    localparam int unsigned TAIL_CYCLES     = 10;

    // One reading per tick, field order as the result ports
    typedef struct packed {
        logic        trig;
        logic        busy;
        logic        done;
        logic        tmo;
        logic [19:0] pulse;
        logic [17:0] mm;
    } t_reading;

    localparam t_reading IDLE_READING    = '0;
    localparam t_reading TIMEOUT_READING = {1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 18'd0};

    typedef enum logic {
        ROW_TICK,
        ROW_TIMEOUT
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [9:0]  timeout;
        logic        start;
        logic        echo;
        logic        typed;
        t_reading    want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs; every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [9:0]  i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic        i_start_req   = 1'b0;
    logic        i_echo        = 1'b0;
    logic        i_stall       = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic        o_trigger;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_timed_out;
    logic [19:0] o_echo_width;
    logic [17:0] o_dist_mm;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ultrasonic_echo_ranger i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_req   (i_start_req),
        .i_echo        (i_echo),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_trigger     (o_trigger),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_timed_out   (o_timed_out),
        .o_echo_width  (o_echo_width),
        .o_dist_mm     (o_dist_mm)
    );

    // ------------------------------------------------------------------
    // Ranging predictor: its own phase, tick count, held width and timeout
    // ------------------------------------------------------------------
    uer_pkg::t_phase rng_phase    = uer_pkg::PH_IDLE;
    logic [19:0]     rng_elapsed  = '0;
    logic [19:0]     rng_pulse    = '0;
    logic [9:0]      rng_limit_ms = WAKE_TIMEOUT_MS;

    t_reading    predicted_readings [$];
    t_dir_row    dir_rows [$];

    int unsigned fail_count       = 0;
    int unsigned beats_sent       = 0;
    int unsigned ranging_ticks    = 0;
    int unsigned readings_checked = 0;
    int unsigned ranges_done      = 0;
    int unsigned ranges_timed_out = 0;
    int unsigned settings_used    = 0;
    bit          tx_calm          = 1'b0;

    // Advances the predictor by one microsecond tick and returns the reading
    function automatic t_reading predict_reading(input logic start, input logic echo);
        t_reading    r;
        logic [31:0] limit;
        logic [63:0] mm_full;
        r = '0;
        limit = {22'd0, rng_limit_ms} * 32'd1000;
        if (rng_phase == uer_pkg::PH_IDLE && start) begin
            rng_phase = uer_pkg::PH_WAIT_LOW;
            rng_elapsed = '0;
        end
        case (rng_phase)
            uer_pkg::PH_WAIT_LOW: begin
                // the start tick already looks at echo
                if (!echo) begin
                    rng_phase = uer_pkg::PH_PRE_LOW;
                    rng_elapsed = '0;
                end else begin
                    rng_elapsed = rng_elapsed + 20'd1;
                    r.tmo = ({12'd0, rng_elapsed} > limit);
                end
            end
            uer_pkg::PH_PRE_LOW: begin
                rng_elapsed = rng_elapsed + 20'd1;
                if (rng_elapsed >= LOW_LEAD_TICKS) begin
                    rng_phase = uer_pkg::PH_TRIG_HIGH;
                    rng_elapsed = '0;
                end
            end
            uer_pkg::PH_TRIG_HIGH: begin
                r.trig = 1'b1;
                rng_elapsed = rng_elapsed + 20'd1;
                if (rng_elapsed >= PULSE_TICKS) begin
                    rng_phase = uer_pkg::PH_WAIT_RISE;
                    rng_elapsed = '0;
                end
            end
            uer_pkg::PH_WAIT_RISE: begin
                // the rising tick is the first high tick; zero timeout trips on it
                if (echo) begin
                    rng_phase = uer_pkg::PH_MEASURE;
                    rng_elapsed = 20'd1;
                    r.tmo = (limit == 32'd0);
                end else begin
                    rng_elapsed = rng_elapsed + 20'd1;
                    r.tmo = ({12'd0, rng_elapsed} > limit);
                end
            end
            uer_pkg::PH_MEASURE: begin
                if (!echo) begin
                    r.done = 1'b1;
                    rng_pulse = rng_elapsed;
                    rng_phase = uer_pkg::PH_IDLE;
                    rng_elapsed = '0;
                end else begin
                    rng_elapsed = rng_elapsed + 20'd1;
                    r.tmo = ({12'd0, rng_elapsed} > limit);
                end
            end
            default: ;
        endcase
        if (r.tmo) begin
            r.done = 1'b1;
            rng_pulse = '0;
            rng_phase = uer_pkg::PH_IDLE;
            rng_elapsed = '0;
        end
        mm_full = ({44'd0, rng_pulse} * 64'd343 + 64'd999) / 64'd2000;
        r.busy = (rng_phase != uer_pkg::PH_IDLE);
        r.pulse = rng_pulse;
        r.mm = mm_full[17:0];
        return r;
    endfunction

    function automatic void put_row(input t_row_kind kind, input logic [9:0] timeout,
                                    input logic start, input logic echo,
                                    input logic typed, input t_reading want);
        t_dir_row row;
        row.kind = kind;
        row.timeout = timeout;
        row.start = start;
        row.echo = echo;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    // One line per bad field
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on reading %0d: %s got %0d, expected %0d",
                 readings_checked, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Tick sender: random gap, then hold the beat until the block takes it.
    // Inputs change on the falling edge; acceptance is seen at the rising one.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic start, input logic echo,
                             input logic typed = 1'b0, input t_reading want = '0);
        int unsigned gap;
        t_reading    predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_start_req <= start;
        i_echo <= echo;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
        if (rng_phase != uer_pkg::PH_IDLE || start)
            ranging_ticks++;
        predicted = predict_reading(start, echo);
        // a typed row is held to the value written in the table
        predicted_readings.push_back(typed ? want : predicted);
    endtask

    // Steers echo so that any open cycle ends within a few ticks
    task automatic settle_to_idle();
        logic echo;
        while (rng_phase != uer_pkg::PH_IDLE) begin
            case (rng_phase)
                uer_pkg::PH_WAIT_RISE: echo = 1'b1;
                uer_pkg::PH_WAIT_LOW, uer_pkg::PH_MEASURE: echo = 1'b0;
                default: echo = ($urandom_range(0, 1) != 0);
            endcase
            send_tick(1'b0, echo);
        end
    endtask

    // Timeout writes only with the block idle and every reading back
    task automatic apply_timeout(input logic [9:0] value);
        settle_to_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rng_limit_ms = value;
        settings_used++;
    endtask

    // One ranging cycle as the sensor would answer it: echo still high for
    // `hold` ticks (start tick included), then low; trigger span; `lag` low
    // ticks before the rise; `pulse_len` high ticks; then the fall.
    task automatic ranging_run(input int unsigned hold, input int unsigned lag,
                               input int unsigned pulse_len);
        int unsigned i;
        for (i = 0; i < hold; i++)
            send_tick(i == 0, 1'b1);
        send_tick(hold == 0, 1'b0);
        // start and echo are don't-cares while the trigger is driven
        for (i = 0; i < TRIG_SPAN; i++)
            send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        for (i = 0; i < lag; i++)
            send_tick($urandom_range(0, 1) != 0, 1'b0);
        for (i = 0; i < pulse_len; i++)
            send_tick($urandom_range(0, 1) != 0, 1'b1);
        send_tick($urandom_range(0, 1) != 0, 1'b0);
    endtask

    // Mostly clean cycles with random timing; the rest is raw noise, which
    // also leaves cycles half done for the next run to trip over
    task automatic random_sequence();
        int unsigned hold;
        int unsigned lag;
        int unsigned pulse_len;
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 75) begin
            repeat ($urandom_range(0, 3))
                send_tick(1'b0, $urandom_range(0, 1) != 0);
            hold = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            lag = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            pulse_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                    : $urandom_range(1, 40);
            ranging_run(hold, lag, pulse_len);
        end else begin
            repeat ($urandom_range(4, 30))
                send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Reading checker: every accepted result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reading_check
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_readings.size() == 0) begin
                flag_mismatch("reading with nothing pending", 32'd1, 32'd0);
            end else begin
                want = predicted_readings.pop_front();
                if (o_trigger !== want.trig)
                    flag_mismatch("trigger", {31'd0, o_trigger}, {31'd0, want.trig});
                if (o_busy_res !== want.busy)
                    flag_mismatch("busy", {31'd0, o_busy_res}, {31'd0, want.busy});
                if (o_done_res !== want.done)
                    flag_mismatch("done", {31'd0, o_done_res}, {31'd0, want.done});
                if (o_timed_out !== want.tmo)
                    flag_mismatch("timed_out", {31'd0, o_timed_out}, {31'd0, want.tmo});
                if (o_echo_width !== want.pulse)
                    flag_mismatch("echo_width", {12'd0, o_echo_width}, {12'd0, want.pulse});
                if (o_dist_mm !== want.mm)
                    flag_mismatch("dist_mm", {14'd0, o_dist_mm}, {14'd0, want.mm});
                if (want.done && !want.tmo)
                    ranges_done++;
                if (want.tmo)
                    ranges_timed_out++;
            end
            readings_checked++;
        end
    end

    // Result side: random stall before each beat, with calm stretches
    initial begin : result_sink
        int unsigned hold_off;
        bit          rx_calm;
        rx_calm = 1'b0;
        forever begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            hold_off = rx_calm ? 0 : $urandom_range(0, 10);
            if (hold_off != 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (hold_off - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [9:0]  plan [6];
        int unsigned target;
        int          p;
        int          n;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run at the wake-up timeout of 50 ms first
        put_row(ROW_TICK, '0, 1'b0, 1'b0, 1'b1, IDLE_READING);   // quiet after reset
        put_row(ROW_TICK, '0, 1'b0, 1'b1, 1'b1, IDLE_READING);   // echo alone does nothing
        put_row(ROW_TICK, '0, 1'b1, 1'b1, 1'b0, '0);             // start with echo still high
        put_row(ROW_TICK, '0, 1'b1, 1'b1, 1'b0, '0);             // start ignored while busy
        put_row(ROW_TICK, '0, 1'b0, 1'b0, 1'b0, '0);             // echo low found
        put_row(ROW_TICK, '0, 1'b0, 1'b1, 1'b0, '0);             // low lead
        put_row(ROW_TICK, '0, 1'b1, 1'b0, 1'b0, '0);
        for (n = 0; n < 12; n++)                                 // trigger high
            put_row(ROW_TICK, '0, n[1], n[0], 1'b0, '0);
        put_row(ROW_TICK, '0, 1'b0, 1'b1, 1'b0, '0);             // rise on the first tick
        put_row(ROW_TICK, '0, 1'b0, 1'b1, 1'b0, '0);
        put_row(ROW_TICK, '0, 1'b0, 1'b0, 1'b0, '0);             // fall: two tick width
        put_row(ROW_TIMEOUT, 10'd0, 1'b0, 1'b0, 1'b0, '0);       // zero timeout
        put_row(ROW_TICK, '0, 1'b1, 1'b1, 1'b1, TIMEOUT_READING); // trips on the start tick
        put_row(ROW_TICK, '0, 1'b1, 1'b0, 1'b0, '0);             // start with echo already low

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_TIMEOUT)
                apply_timeout(dir_rows[i].timeout);
            else
                send_tick(dir_rows[i].start, dir_rows[i].echo,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: a run of cycles under each timeout setting,
        // the register extremes among them
        plan[0] = 10'd1023;
        plan[1] = 10'd1;
        plan[2] = 10'd0;
        plan[3] = 10'd1000;
        plan[4] = 10'($urandom_range(2, 999));
        plan[5] = WAKE_TIMEOUT_MS;
        for (p = 0; p < 6; p++) begin
            apply_timeout(plan[p]);
            target = ranging_ticks + PHASE_TICKS;
            while (ranging_ticks < target)
                random_sequence();
            if (plan[p] == 10'd1) begin
                // 1 ms: echo held high one tick past the limit, so the
                // measurement must trip on exactly that tick
                tx_calm = 1'b0;
                settle_to_idle();
                ranging_run(0, 0, 1001);
            end
        end

        // Drain, then give the pipeline time to show any stray beat
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_readings.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d tick beats sent, %0d of them in a ranging cycle; %0d readings checked",
                 beats_sent, ranging_ticks, readings_checked);
        $display("%0d ranges completed, %0d timed out, across %0d timeout settings",
                 ranges_done, ranges_timed_out, settings_used);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin : watchdog
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* ultrasonic_echo_ranger.f */
src/uer_pkg.sv
src/ultrasonic_echo_ranger.sv
src/uer_checker.sv
tb/ultrasonic_echo_ranger_tb.sv
